// ----- design/page_buffer_pool_manager_macros.svh -----
// Assertion macros shared by the page buffer pool RTL.
// Expects signals named clock and reset in the including module.
`ifndef PAGE_BUFFER_POOL_MANAGER_MACROS_SVH
`define PAGE_BUFFER_POOL_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold on every clock edge out of reset
`define PBPM_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("pbpm assertion failed");
// Antecedent implies consequent on the same edge
`define PBPM_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbpm assertion failed");
`else
`define PBPM_ASSERT_ALWAYS(lbl, cond)
`define PBPM_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- design/pbpm_pkg.sv -----
// Shared codes, constants and controller/datapath interface structs
// for the page buffer pool manager. No dependencies.
package pbpm_pkg;

   localparam int ACT_W      = 3;
   localparam int ST_W       = 3;
   localparam int LIMIT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // request actions
   localparam logic [ACT_W-1:0] ACT_GET   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_UNFIX = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MARK  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REL   = 3'd4;

   // response status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_NO_BUF   = 3'd1;
   localparam logic [ST_W-1:0] ST_FIXED    = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_IN   = 3'd3;
   localparam logic [ST_W-1:0] ST_UNFIXED  = 3'd4;
   localparam logic [ST_W-1:0] ST_ALREADY  = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT  = 1'd1;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 5'd16;

   // response frame / write-back source selects
   localparam logic [1:0] FRSEL_NONE = 2'd0;
   localparam logic [1:0] FRSEL_FF   = 2'd1;
   localparam logic [1:0] FRSEL_REC  = 2'd2;
   localparam logic [1:0] WBSEL_NONE  = 2'd0;
   localparam logic [1:0] WBSEL_SAVED = 2'd1;
   localparam logic [1:0] WBSEL_REC   = 2'd2;

   typedef struct packed {
      logic            load_req;
      logic            idx_clr;
      logic            idx_inc;
      logic            victim_pos;
      logic            tag_from_rec;
      logic            fr_from_idx;
      logic            fr_from_rec;
      logic            fr_from_free;
      logic            fr_from_new;
      logic            set_fixed;
      logic            clr_fixed;
      logic            set_dirty;
      logic            unlink;
      logic            drop_rec;
      logic            push_free;
      logic            capture_wb;
      logic            link_head;
      logic            install;
      logic            emit;
      logic [ST_W-1:0] emit_status;
      logic [1:0]      emit_frame;
      logic [1:0]      emit_wb;
      logic            emit_read;
      logic            emit_last;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             req_dirty;
      logic             hit;
      logic             idx_last;
      logic             walk_end;
      logic             fr_fixed;
      logic             rec_match;
      logic             rec_fixed;
      logic             rec_dirty;
      logic             rec_is_fr;
      logic             free_avail;
      logic             can_create;
      logic             out_free;
   } stat_type;

endpackage

// ----- design/page_buffer_pool_manager.sv -----
// Top level of the page buffer pool manager: ports, configuration registers,
// controller and datapath. Depends on pbpm_pkg, pbpm_ctrl, pbpm_datapath.
//
// One request is handled at a time. A tag lookup scans frames 0 to FRAMES - 1,
// one per cycle, and stops at the first match. A get or alloc that misses is
// served from the free stack, else from a new frame, else by a victim search
// that scans one recency position per cycle. Unfix or mark on an absent page
// answers after the full scan; on a pinned page it updates the marks, then
// searches the recency list for the frame and moves it to the head. A file
// release walks the recency list from the head, one entry per cycle except
// while a dirty page waits for a free response register, emitting one
// transaction per dirty page written back plus a final one. The response
// register lets the next request be taken while a response waits. No clearing
// pass follows reset.
module page_buffer_pool_manager #(
   parameter int FRAMES       = 16,
   parameter int FILE_ID_BITS = 6,
   parameter int PAGE_BITS    = 16,
   localparam int FR_W  = $clog2(FRAMES),
   localparam int CNT_W = $clog2(FRAMES + 1),
   localparam int REQ_W = ((FILE_ID_BITS + PAGE_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_W = ((FR_W + 2 + FILE_ID_BITS + PAGE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = file_id, page_number, mark_dirty; tuser = action
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,
   input  logic [pbpm_pkg::ACT_W-1:0]        req_tuser,
   // response: tdata = frame_index, read_request, write_back, write_file,
   // write_page; tuser = status
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,
   output logic [pbpm_pkg::ST_W-1:0]         rsp_tuser,
   output logic                              rsp_tlast,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbpm_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic                         policy_ff;
   logic [pbpm_pkg::LIMIT_W-1:0] limit_ff;
   pbpm_pkg::cmd_type            cmd;
   pbpm_pkg::stat_type           stat;
   logic [FR_W-1:0]              frame;
   logic                         read, wb;
   logic [FILE_ID_BITS-1:0]      wfile;
   logic [PAGE_BITS-1:0]         wpage;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         limit_ff  <= pbpm_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pbpm_pkg::CSR_POLICY: policy_ff <= csr_data[0];
            pbpm_pkg::CSR_LIMIT:  limit_ff  <= csr_data[pbpm_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   pbpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   pbpm_datapath #(
      .FRAMES       (FRAMES),
      .FILE_ID_BITS (FILE_ID_BITS),
      .PAGE_BITS    (PAGE_BITS),
      .FR_W         (FR_W),
      .CNT_W        (CNT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_tuser),
      .req_file   (req_tdata[FILE_ID_BITS-1:0]),
      .req_page   (req_tdata[FILE_ID_BITS +: PAGE_BITS]),
      .req_dirty  (req_tdata[FILE_ID_BITS + PAGE_BITS]),
      .policy     (policy_ff),
      .limit      (limit_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_frame  (frame),
      .rsp_read   (read),
      .rsp_wb     (wb),
      .rsp_wfile  (wfile),
      .rsp_wpage  (wpage),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({wpage, wfile, wb, read, frame});

endmodule

// ----- design/pbpm_ctrl.sv -----
// Sequencing state machine of the page buffer pool manager.
// Depends on pbpm_pkg; drives pbpm_datapath through cmd_type.
module pbpm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pbpm_pkg::ACT_W-1:0] req_action,
   input  pbpm_pkg::stat_type         stat,
   output pbpm_pkg::cmd_type          cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LOOKUP  = 4'd1;
   localparam logic [3:0] S_HIT     = 4'd2;
   localparam logic [3:0] S_TAKE    = 4'd3;
   localparam logic [3:0] S_VICTIM  = 4'd4;
   localparam logic [3:0] S_INSTALL = 4'd5;
   localparam logic [3:0] S_SEARCH  = 4'd6;
   localparam logic [3:0] S_HEAD    = 4'd7;
   localparam logic [3:0] S_REL     = 4'd8;
   localparam logic [3:0] S_EMPTY   = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and command decode
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               cmd.idx_clr  = 1'b1;
               case (req_action) inside
                  pbpm_pkg::ACT_GET, pbpm_pkg::ACT_ALLOC,
                  pbpm_pkg::ACT_UNFIX, pbpm_pkg::ACT_MARK: state_in = S_LOOKUP;
                  pbpm_pkg::ACT_REL:                       state_in = S_REL;
                  default:                                 state_in = S_EMPTY;
               endcase
            end
         end
         S_LOOKUP: begin
            if (stat.hit) begin
               cmd.fr_from_idx = 1'b1;
               state_in        = S_HIT;
            end else if (!stat.idx_last) begin
               cmd.idx_inc = 1'b1;
            end else if (stat.act == pbpm_pkg::ACT_GET || stat.act == pbpm_pkg::ACT_ALLOC) begin
               state_in = S_TAKE;
            end else if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = pbpm_pkg::ST_NOT_IN;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_HIT: begin
            cmd.emit_last  = 1'b1;
            cmd.emit_frame = pbpm_pkg::FRSEL_FF;
            if (stat.act == pbpm_pkg::ACT_ALLOC) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = pbpm_pkg::ST_ALREADY;
                  cmd.emit_frame  = pbpm_pkg::FRSEL_NONE;
                  state_in        = S_IDLE;
               end
            end else if (stat.act == pbpm_pkg::ACT_GET) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = stat.fr_fixed ? pbpm_pkg::ST_FIXED : pbpm_pkg::ST_OK;
                  cmd.set_fixed   = !stat.fr_fixed;
                  state_in        = S_IDLE;
               end
            end else if (!stat.fr_fixed) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = pbpm_pkg::ST_UNFIXED;
                  state_in        = S_IDLE;
               end
            end else begin
               // pinned page: update marks, then move it to the head
               cmd.set_dirty = (stat.act == pbpm_pkg::ACT_MARK) || stat.req_dirty;
               cmd.clr_fixed = (stat.act == pbpm_pkg::ACT_UNFIX);
               cmd.idx_clr   = 1'b1;
               state_in      = S_SEARCH;
            end
         end
         S_TAKE: begin
            if (stat.free_avail) begin
               cmd.fr_from_free = 1'b1;
               state_in         = S_INSTALL;
            end else if (stat.can_create) begin
               cmd.fr_from_new = 1'b1;
               state_in        = S_INSTALL;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_VICTIM;
            end
         end
         S_VICTIM: begin
            cmd.victim_pos   = 1'b1;
            cmd.tag_from_rec = 1'b1;
            if (stat.walk_end) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = pbpm_pkg::ST_NO_BUF;
                  cmd.emit_last   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (!stat.rec_fixed) begin
               cmd.fr_from_rec = 1'b1;
               cmd.capture_wb  = 1'b1;
               cmd.drop_rec    = 1'b1;
               cmd.unlink      = 1'b1;
               state_in        = S_INSTALL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_INSTALL: begin
            if (stat.out_free) begin
               cmd.link_head   = 1'b1;
               cmd.install     = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = pbpm_pkg::ST_OK;
               cmd.emit_frame  = pbpm_pkg::FRSEL_FF;
               cmd.emit_wb     = pbpm_pkg::WBSEL_SAVED;
               cmd.emit_read   = (stat.act == pbpm_pkg::ACT_GET);
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SEARCH: begin
            if (stat.walk_end) begin
               state_in = S_HEAD;
            end else if (stat.rec_is_fr) begin
               cmd.unlink = 1'b1;
               state_in   = S_HEAD;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_HEAD: begin
            if (stat.out_free) begin
               cmd.link_head   = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_status = pbpm_pkg::ST_OK;
               cmd.emit_frame  = pbpm_pkg::FRSEL_FF;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_REL: begin
            cmd.tag_from_rec = 1'b1;
            if (stat.walk_end) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = pbpm_pkg::ST_OK;
                  cmd.emit_last   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (!stat.rec_match) begin
               cmd.idx_inc = 1'b1;
            end else if (stat.rec_fixed) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = pbpm_pkg::ST_FIXED;
                  cmd.emit_frame  = pbpm_pkg::FRSEL_REC;
                  cmd.emit_last   = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (!stat.rec_dirty || stat.out_free) begin
               // release this page; a dirty one reports its write-back
               cmd.emit        = stat.rec_dirty;
               cmd.emit_status = pbpm_pkg::ST_OK;
               cmd.emit_frame  = pbpm_pkg::FRSEL_REC;
               cmd.emit_wb     = pbpm_pkg::WBSEL_REC;
               cmd.drop_rec    = 1'b1;
               cmd.unlink      = 1'b1;
               cmd.push_free   = 1'b1;
            end
         end
         S_EMPTY: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- design/pbpm_datapath.sv -----
// Frame tags, marks, recency list, free stack, counters and response register.
// Depends on pbpm_pkg and page_buffer_pool_manager_macros.svh.
`include "page_buffer_pool_manager_macros.svh"
module pbpm_datapath #(
   parameter int FRAMES       = 16,
   parameter int FILE_ID_BITS = 6,
   parameter int PAGE_BITS    = 16,
   parameter int FR_W         = 4,
   parameter int CNT_W        = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbpm_pkg::cmd_type               cmd,
   output pbpm_pkg::stat_type              stat,
   input  logic [pbpm_pkg::ACT_W-1:0]      req_action,
   input  logic [FILE_ID_BITS-1:0]         req_file,
   input  logic [PAGE_BITS-1:0]            req_page,
   input  logic                            req_dirty,
   input  logic                            policy,
   input  logic [pbpm_pkg::LIMIT_W-1:0]    limit,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pbpm_pkg::ST_W-1:0]       rsp_status,
   output logic [FR_W-1:0]                 rsp_frame,
   output logic                            rsp_read,
   output logic                            rsp_wb,
   output logic [FILE_ID_BITS-1:0]         rsp_wfile,
   output logic [PAGE_BITS-1:0]            rsp_wpage,
   output logic                            rsp_last
);

   // request latch
   logic [pbpm_pkg::ACT_W-1:0] act_ff;
   logic [FILE_ID_BITS-1:0]    file_ff;
   logic [PAGE_BITS-1:0]       page_ff;
   logic                       rdirty_ff;

   // frame state
   logic [FILE_ID_BITS-1:0] tag_file_ff [FRAMES];
   logic [PAGE_BITS-1:0]    tag_page_ff [FRAMES];
   logic [FRAMES-1:0]       resident_ff, resident_in;
   logic [FRAMES-1:0]       fixed_ff, fixed_in;
   logic [FRAMES-1:0]       dirty_ff, dirty_in;
   logic [FR_W-1:0]         rec_ff [FRAMES];
   logic [FR_W-1:0]         rec_in [FRAMES];
   logic [CNT_W-1:0]        res_cnt_ff, res_cnt_in;
   logic [FR_W-1:0]         stk_ff [FRAMES];
   logic [CNT_W-1:0]        free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]        created_ff;

   // walk and working registers
   logic [CNT_W-1:0]        idx_ff;
   logic [FR_W-1:0]         fr_ff;
   logic                    wb_ff;
   logic [FILE_ID_BITS-1:0] wb_file_ff;
   logic [PAGE_BITS-1:0]    wb_page_ff;

   // response register
   logic                    out_valid_ff;
   logic [pbpm_pkg::ST_W-1:0] out_status_ff;
   logic [FR_W-1:0]         out_frame_ff;
   logic                    out_read_ff, out_wb_ff, out_last_ff;
   logic [FILE_ID_BITS-1:0] out_wfile_ff;
   logic [PAGE_BITS-1:0]    out_wpage_ff;

   logic [CNT_W-1:0] vpos;
   logic [FR_W-1:0]  walk_pos, rec_at, taddr, stk_top;
   logic             file_match, out_free;

   // walk position: victim scan runs from the tail for LRU, head for MRU
   assign vpos     = policy ? idx_ff : (res_cnt_ff - CNT_W'(1) - idx_ff);
   assign walk_pos = cmd.victim_pos ? vpos[FR_W-1:0] : idx_ff[FR_W-1:0];
   assign rec_at   = rec_ff[walk_pos];
   assign taddr    = cmd.tag_from_rec ? rec_at : idx_ff[FR_W-1:0];
   assign stk_top  = stk_ff[free_cnt_ff[FR_W-1:0] - FR_W'(1)];
   assign file_match = (tag_file_ff[taddr] == file_ff);
   assign out_free = !out_valid_ff || rsp_ready;

   // status to the controller
   always_comb begin
      stat.act        = act_ff;
      stat.req_dirty  = rdirty_ff;
      stat.hit        = resident_ff[taddr] && file_match && (tag_page_ff[taddr] == page_ff);
      stat.idx_last   = (idx_ff == CNT_W'(FRAMES - 1));
      stat.walk_end   = (idx_ff >= res_cnt_ff);
      stat.fr_fixed   = fixed_ff[fr_ff];
      stat.rec_match  = resident_ff[taddr] && file_match;
      stat.rec_fixed  = fixed_ff[rec_at];
      stat.rec_dirty  = dirty_ff[rec_at];
      stat.rec_is_fr  = (rec_at == fr_ff);
      stat.free_avail = (free_cnt_ff != '0);
      stat.can_create = (32'(created_ff) < 32'(FRAMES)) && (32'(created_ff) < 32'(limit));
      stat.out_free   = out_free;
   end

   // mark bits
   always_comb begin
      resident_in = resident_ff;
      fixed_in    = fixed_ff;
      dirty_in    = dirty_ff;
      if (cmd.set_fixed) fixed_in[fr_ff] = 1'b1;
      if (cmd.clr_fixed) fixed_in[fr_ff] = 1'b0;
      if (cmd.set_dirty) dirty_in[fr_ff] = 1'b1;
      if (cmd.drop_rec) begin
         resident_in[rec_at] = 1'b0;
         dirty_in[rec_at]    = 1'b0;
      end
      if (cmd.install) begin
         resident_in[fr_ff] = 1'b1;
         fixed_in[fr_ff]    = 1'b1;
         dirty_in[fr_ff]    = 1'b0;
      end
   end

   // recency list: unlink compacts toward head, link shifts toward tail
   always_comb begin
      for (int j = 0; j < FRAMES; j++) begin
         rec_in[j] = rec_ff[j];
      end
      res_cnt_in = res_cnt_ff;
      if (cmd.unlink) begin
         for (int j = 0; j < FRAMES - 1; j++) begin
            if (CNT_W'(j) >= {{(CNT_W-FR_W){1'b0}}, walk_pos} &&
                CNT_W'(j + 1) < res_cnt_ff) begin
               rec_in[j] = rec_ff[j + 1];
            end
         end
         res_cnt_in = res_cnt_ff - CNT_W'(1);
      end else if (cmd.link_head && (res_cnt_ff < CNT_W'(FRAMES))) begin
         for (int j = 1; j < FRAMES; j++) begin
            rec_in[j] = rec_ff[j - 1];
         end
         rec_in[0]  = fr_ff;
         res_cnt_in = res_cnt_ff + CNT_W'(1);
      end
   end

   // free stack count
   always_comb begin
      free_cnt_in = free_cnt_ff;
      if (cmd.fr_from_free) begin
         free_cnt_in = free_cnt_ff - CNT_W'(1);
      end else if (cmd.push_free && (free_cnt_ff < CNT_W'(FRAMES))) begin
         free_cnt_in = free_cnt_ff + CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         resident_ff  <= '0;
         fixed_ff     <= '0;
         dirty_ff     <= '0;
         res_cnt_ff   <= '0;
         free_cnt_ff  <= '0;
         created_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         resident_ff <= resident_in;
         fixed_ff    <= fixed_in;
         dirty_ff    <= dirty_in;
         res_cnt_ff  <= res_cnt_in;
         free_cnt_ff <= free_cnt_in;
         if (cmd.fr_from_new) created_ff <= created_ff + CNT_W'(1);
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      for (int j = 0; j < FRAMES; j++) begin
         rec_ff[j] <= rec_in[j];
      end
      if (cmd.load_req) begin
         act_ff    <= req_action;
         file_ff   <= req_file;
         page_ff   <= req_page;
         rdirty_ff <= req_dirty;
         wb_ff     <= 1'b0;
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.fr_from_idx)  fr_ff <= idx_ff[FR_W-1:0];
      if (cmd.fr_from_rec)  fr_ff <= rec_at;
      if (cmd.fr_from_free) fr_ff <= stk_top;
      if (cmd.fr_from_new)  fr_ff <= created_ff[FR_W-1:0];
      if (cmd.capture_wb) begin
         wb_ff      <= dirty_ff[rec_at];
         wb_file_ff <= tag_file_ff[rec_at];
         wb_page_ff <= tag_page_ff[rec_at];
      end
      if (cmd.push_free && (free_cnt_ff < CNT_W'(FRAMES))) begin
         stk_ff[free_cnt_ff[FR_W-1:0]] <= rec_at;
      end
      if (cmd.install) begin
         tag_file_ff[fr_ff] <= file_ff;
         tag_page_ff[fr_ff] <= page_ff;
      end
      if (cmd.emit) begin
         out_status_ff <= cmd.emit_status;
         out_read_ff   <= cmd.emit_read;
         out_last_ff   <= cmd.emit_last;
         case (cmd.emit_frame)
            pbpm_pkg::FRSEL_FF:  out_frame_ff <= fr_ff;
            pbpm_pkg::FRSEL_REC: out_frame_ff <= rec_at;
            default:             out_frame_ff <= '0;
         endcase
         case (cmd.emit_wb)
            pbpm_pkg::WBSEL_SAVED: begin
               out_wb_ff    <= wb_ff;
               out_wfile_ff <= wb_ff ? wb_file_ff : '0;
               out_wpage_ff <= wb_ff ? wb_page_ff : '0;
            end
            pbpm_pkg::WBSEL_REC: begin
               out_wb_ff    <= 1'b1;
               out_wfile_ff <= file_ff;
               out_wpage_ff <= tag_page_ff[rec_at];
            end
            default: begin
               out_wb_ff    <= 1'b0;
               out_wfile_ff <= '0;
               out_wpage_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_frame  = out_frame_ff;
   assign rsp_read   = out_read_ff;
   assign rsp_wb     = out_wb_ff;
   assign rsp_wfile  = out_wfile_ff;
   assign rsp_wpage  = out_wpage_ff;
   assign rsp_last   = out_last_ff;

   // a pinned or modified frame is always resident
   `PBPM_ASSERT_ALWAYS(a_fixed_resident, (fixed_ff & ~resident_ff) == '0)
   `PBPM_ASSERT_ALWAYS(a_dirty_resident, (dirty_ff & ~resident_ff) == '0)
   // every listed or stacked frame was created at some point
   `PBPM_ASSERT_ALWAYS(a_frames_accounted, 32'(res_cnt_ff) + 32'(free_cnt_ff) <= 32'(created_ff))
   // a free stack pop never happens on an empty stack
   `PBPM_ASSERT_IMPLY(a_pop_nonempty, cmd.fr_from_free, free_cnt_ff != '0)

endmodule
